FILE: rtl/lct_pkg.sv
// ----------------------------------------------------------------------------
// LRU cache tracker package
// Shared widths, command codes, reset values and the result record.
// ----------------------------------------------------------------------------
package lct_pkg;

  localparam int KEY_W       = 64;
  localparam int CAP_W       = 7;
  localparam int OCC_W       = 7;
  localparam int ENTRIES_DEF = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Command codes carried on the input tuser bit.
  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // One result record, as handed from the sequencer to the output register.
  typedef struct packed {
    logic             hit;
    logic             ev_valid;
    logic [KEY_W-1:0] ev_key;
    logic             err;
    logic [OCC_W-1:0] occ;
  } res_t;

endpackage

FILE: rtl/lru_cache_tracker.sv
// ----------------------------------------------------------------------------
// LRU cache tracker
// Fully associative store of 64-bit keys kept in recency order, with access
// (lookup, promote or insert with eviction) and remove commands.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake          Contents
// in_      in   tvalid/tready      tdata: key[63:0]; tuser: cmd[0]
// out_     out  tvalid/tready      tdata: hit, evicted_valid, victim_key,
//                                  not_found_error, occupancy, zero pad
// cfg_     in   wr_en (no wait)    wr_data: capacity[6:0]
//
// The search reads the recency list one entry a cycle up to the matching key,
// and the gap-closing pass moves every later entry down one place, both
// through the single read and write port of the key memory. in_tready is high
// only while the sequencer is idle. A finished result sits in the output
// register, so a new beat is taken while the previous result is still stalled;
// the sequencer holds its next result until that register frees up. Reset is
// synchronous; it empties the list by clearing the entry count, so no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module lru_cache_tracker #(
  parameter int ENTRIES = lct_pkg::ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input beats.
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [63:0]               in_tdata,   // [63:0] key
  input  logic [0:0]                in_tuser,   // [0] cmd
  // Result beats.
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [79:0]               out_tdata,  // [0] hit, [1] evicted_valid,
                                                // [65:2] victim_key,
                                                // [66] not_found_error,
                                                // [73:67] occupancy, [79:74] 0
  // Capacity register write.
  input  logic                      cfg_wr_en,
  input  logic [lct_pkg::CAP_W-1:0] cfg_wr_data
);
  import lct_pkg::*;

  // Memory address width and a count width that can also hold ENTRIES itself.
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [CAP_W-1:0] cap_r;
  logic             seq_idle, seq_done, take, start;
  res_t             seq_res;
  res_t             out_res_r;
  logic             out_valid_r;

  // The user must write capacity only while no beat is in flight; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  assign in_tready = seq_idle;
  assign start     = in_tvalid && in_tready;

  // The output register takes a result when it is empty or being drained.
  assign take = seq_done && (!out_valid_r || out_tready);

  lct_seq #(.ENTRIES(ENTRIES), .AW(AW), .CW(CW)) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (start),
    .cmd_i   (in_tuser[0]),
    .key_i   (in_tdata),
    .cap_i   (cap_r),
    .idle_o  (seq_idle),
    .done_o  (seq_done),
    .take_i  (take),
    .res_o   (seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (take) begin
      out_res_r <= seq_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_res_r.occ, out_res_r.err, out_res_r.ev_key,
                       out_res_r.ev_valid, out_res_r.hit};

endmodule

FILE: rtl/lct_keyram.sv
// ----------------------------------------------------------------------------
// LRU cache tracker key memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module lct_keyram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int W     = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/lct_seq.sv
// ----------------------------------------------------------------------------
// LRU cache tracker sequencer
// Walks the recency list through the key memory: search, then close the gap
// and/or append as needed, using one key comparator and one memory port pair.
// ----------------------------------------------------------------------------
module lct_seq #(
  parameter int ENTRIES = 64,
  parameter int AW      = 6,
  parameter int CW      = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic                      cmd_i,
  input  logic [lct_pkg::KEY_W-1:0] key_i,
  input  logic [lct_pkg::CAP_W-1:0] cap_i,
  output logic                      idle_o,
  output logic                      done_o,
  input  logic                      take_i,
  output lct_pkg::res_t             res_o
);
  import lct_pkg::*;

  localparam int CAPW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CAPW-1:0] ENT_X = CAPW'(ENTRIES);
  localparam logic [CW-1:0]   ONE   = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_DECIDE, S_SHIFT, S_APPEND, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic             cmd_r, cmd_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [KEY_W-1:0] head_r, head_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    ia_r, ia_nxt;
  logic [CW-1:0]    pidx_r, pidx_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  logic             pend_r, pend_nxt;
  logic             found_r, found_nxt;
  logic             app_r, app_nxt;
  res_t             res_r, res_nxt;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [KEY_W-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0]    wr_idx;
  logic [CAPW-1:0]  cap_ext, cap_eff, cnt_ext;
  logic             match, last, full;

  lct_keyram #(.DEPTH(ENTRIES), .AW(AW), .W(KEY_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cap_ext = CAPW'(cap_i);
  assign cnt_ext = CAPW'(count_r);
  assign cap_eff = (cap_ext > ENT_X) ? ENT_X : cap_ext;
  assign full    = (cnt_ext >= cap_eff);
  assign match   = pend_r && (ram_rdata == key_r);
  assign last    = pend_r && (pidx_r == count_r - ONE);
  assign wr_idx  = pidx_r - ONE;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    key_nxt   = key_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    ia_nxt    = ia_r;
    pidx_nxt  = pidx_r;
    pos_nxt   = pos_r;
    pend_nxt  = pend_r;
    found_nxt = found_r;
    app_nxt   = app_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = wr_idx[AW-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = ia_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start_i) begin
          cmd_nxt   = cmd_i;
          key_nxt   = key_i;
          ia_nxt    = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          state_nxt = S_SEARCH;
        end
      end

      S_SEARCH: begin
        // The head entry is always the first one read; keep it for eviction.
        if (pend_r && (pidx_r == '0)) begin
          head_nxt = ram_rdata;
        end
        if (match) begin
          found_nxt = 1'b1;
          pos_nxt   = pidx_r;
          pend_nxt  = 1'b0;
          state_nxt = S_DECIDE;
        end else if ((count_r == '0) || last) begin
          pend_nxt  = 1'b0;
          state_nxt = S_DECIDE;
        end else if (ia_r < count_r) begin
          ram_re   = 1'b1;
          pidx_nxt = ia_r;
          pend_nxt = 1'b1;
          ia_nxt   = ia_r + ONE;
        end else begin
          pend_nxt = 1'b0;
        end
      end

      S_DECIDE: begin
        res_nxt   = '0;
        app_nxt   = 1'b0;
        pend_nxt  = 1'b0;
        state_nxt = S_DONE;
        if (cmd_r == CMD_ACCESS) begin
          if (found_r) begin
            res_nxt.hit = 1'b1;
            app_nxt     = 1'b1;
            ia_nxt      = pos_r + ONE;
            state_nxt   = S_SHIFT;
          end else if (full) begin
            res_nxt.ev_valid = 1'b1;
            if (count_r == '0) begin
              // Zero capacity on an empty list: the new key leaves at once.
              res_nxt.ev_key = key_r;
            end else begin
              res_nxt.ev_key = head_r;
              app_nxt        = 1'b1;
              ia_nxt         = ONE;
              state_nxt      = S_SHIFT;
            end
          end else begin
            state_nxt = S_APPEND;
          end
        end else begin
          if (found_r) begin
            res_nxt.hit = 1'b1;
            ia_nxt      = pos_r + ONE;
            state_nxt   = S_SHIFT;
          end else begin
            res_nxt.err = 1'b1;
          end
        end
      end

      S_SHIFT: begin
        // Entry read last cycle moves down one place.
        if (pend_r) begin
          ram_we = 1'b1;
        end
        if (ia_r < count_r) begin
          ram_re   = 1'b1;
          pidx_nxt = ia_r;
          pend_nxt = 1'b1;
          ia_nxt   = ia_r + ONE;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = count_r - ONE;
            state_nxt = app_r ? S_APPEND : S_DONE;
          end
        end
      end

      S_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = count_r[AW-1:0];
        ram_wdata = key_r;
        count_nxt = count_r + ONE;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (take_i) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
    cmd_r   <= cmd_nxt;
    key_r   <= key_nxt;
    head_r  <= head_nxt;
    ia_r    <= ia_nxt;
    pidx_r  <= pidx_nxt;
    pos_r   <= pos_nxt;
    found_r <= found_nxt;
    app_r   <= app_nxt;
    res_r   <= res_nxt;
  end

  assign idle_o = (state_r == S_IDLE);
  assign done_o = (state_r == S_DONE);

  always_comb begin
    res_o     = res_r;
    res_o.occ = OCC_W'(count_r);
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("entry count above depth");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |=> !idle_o)
    else $error("sequencer idle right after start");

  a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (done_o && !res_o.ev_valid) |-> (res_o.ev_key == '0))
    else $error("evicted key set without eviction");

  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (done_o && res_o.err) |-> (!res_o.hit && !res_o.ev_valid && (cmd_r == CMD_REMOVE)))
    else $error("not-found flag with hit or eviction");

endmodule
